[src/recip_pkg.sv]
// Shared constants and types for the Q0.16 reciprocal pipeline.
`timescale 1ns / 1ps
`default_nettype none

package recip_pkg;

    localparam int unsigned VALUE_W    = 16;
    localparam int unsigned POS_W      = 4;
    localparam int unsigned SEED_ENTRIES = 256;
    localparam int unsigned SEED_IDX_W = 8;
    localparam logic [16:0] FULL_Q16   = 17'h10000;
    localparam logic [15:0] MAX_Q16    = 16'hFFFF;
    localparam logic [33:0] NR_ROUND   = 34'h4000;

    // Seed ROM entry: round(2^25 / (513 + 2*i)); divisor is odd, so no ties.
    localparam int unsigned SEED_NUM   = 32'h0400_0000;
    localparam int unsigned SEED_BASE  = 513;

    // Per-item flags that ride along the pipeline.
    typedef struct packed {
        logic            zero;
        logic [POS_W-1:0] msb;
    } t_side;

endpackage

`default_nettype wire

[src/reciprocal_u16_to_q16_core.sv]
// Pipelined reciprocal of an unsigned 16-bit integer, result in unsigned Q0.16.
// o_valid rises once an accepted item has passed all 6 register stages.
// One item per cycle unless stalled; one global stall enable holds every stage together.
// Stages: normalize, seed ROM, a*x0 multiply, x0*(2-a*x0) multiply, round/clamp, denorm.
// Reset (i_rst_n low, synchronous) clears all stage valid bits; data regs are not reset.
`timescale 1ns / 1ps
`default_nettype none

module reciprocal_u16_to_q16_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [recip_pkg::VALUE_W-1:0] i_value,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [recip_pkg::VALUE_W-1:0]      o_recip,
    output logic                               o_div_zero,
    output logic                               o_saturated
);
    import recip_pkg::*;

    // ------------------------------------------------------------------
    // Seed ROM as a constant table, each entry worked out at elaboration.
    // ------------------------------------------------------------------
    logic [15:0] seed_tab [SEED_ENTRIES];

    for (genvar gi = 0; gi < SEED_ENTRIES; gi++) begin : g_seed
        localparam int unsigned D    = SEED_BASE + 2 * gi;
        localparam int unsigned SEED = (SEED_NUM + D) / (2 * D);
        assign seed_tab[gi] = 16'(SEED);
    end

    // ------------------------------------------------------------------
    // Valid bits and the shared stall enable. The pipeline moves whenever
    // the output register is empty or its item is being taken.
    // ------------------------------------------------------------------
    logic [6:1] r_vld;
    logic       en;

    assign en      = !r_vld[6] || i_ready;
    assign o_ready = en;
    assign o_valid = r_vld[6];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[5:1], i_valid};
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: leading-one position and normalize to Q1.15.
    // ------------------------------------------------------------------
    logic [POS_W-1:0]   n_msb;
    logic [VALUE_W-1:0] n_mant;
    t_side              r1_side;
    logic [VALUE_W-1:0] r1_mant;

    always_comb begin
        n_msb = '0;
        for (int i = 0; i < VALUE_W; i++) begin
            if (i_value[i]) begin
                n_msb = POS_W'(i);
            end
        end
        n_mant = i_value << (4'(VALUE_W - 1) - n_msb);
    end

    // ------------------------------------------------------------------
    // Stage 2: seed lookup from the bits just below the leading one.
    // ------------------------------------------------------------------
    t_side              r2_side;
    logic [VALUE_W-1:0] r2_mant;
    logic [15:0]        r2_seed;

    // ------------------------------------------------------------------
    // Stage 3: a*x0 in Q1.15, clamped at 0x10000 so that 2 - a*x0
    // never goes below zero.
    // ------------------------------------------------------------------
    logic [31:0] n_prod1;
    logic [16:0] n_ax;
    t_side       r3_side;
    logic [15:0] r3_seed;
    logic [16:0] r3_ax;

    assign n_prod1 = r2_mant * r2_seed;
    assign n_ax    = ({1'b0, n_prod1[31:16]} > FULL_Q16) ? FULL_Q16
                                                         : {1'b0, n_prod1[31:16]};

    // ------------------------------------------------------------------
    // Stage 4: x0 * (2 - a*x0).
    // ------------------------------------------------------------------
    logic [16:0] n_twom;
    t_side       r4_side;
    logic [32:0] r4_prod;

    assign n_twom = FULL_Q16 - r3_ax;

    // ------------------------------------------------------------------
    // Stage 5: round half up to Q0.16, clamp at 65535 (the value-one case).
    // ------------------------------------------------------------------
    logic [33:0] n_rsum;
    logic [18:0] n_x1w;
    logic [15:0] n_x1;
    t_side       r5_side;
    logic [15:0] r5_x1;

    assign n_rsum = {1'b0, r4_prod} + NR_ROUND;
    assign n_x1w  = n_rsum[33:15];
    assign n_x1   = (n_x1w > 19'(MAX_Q16)) ? MAX_Q16 : n_x1w[15:0];

    // ------------------------------------------------------------------
    // Stage 6: rounded right shift by the msb position, then saturate.
    // ------------------------------------------------------------------
    logic [16:0] n_rnd;
    logic [16:0] n_dsum;
    logic [16:0] n_res;
    logic        n_sat;
    logic [15:0] r6_recip;
    logic        r6_dbz;
    logic        r6_sat;

    always_comb begin
        n_rnd  = (r5_side.msb == '0) ? 17'd0 : (17'd1 << (r5_side.msb - 4'd1));
        n_dsum = {1'b0, r5_x1} + n_rnd;
        n_res  = n_dsum >> r5_side.msb;
        n_sat  = n_res > {1'b0, MAX_Q16};
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_side.zero <= (i_value == '0);
            r1_side.msb  <= n_msb;
            r1_mant      <= n_mant;

            r2_side      <= r1_side;
            r2_mant      <= r1_mant;
            r2_seed      <= seed_tab[r1_mant[VALUE_W-2 -: SEED_IDX_W]];

            r3_side      <= r2_side;
            r3_seed      <= r2_seed;
            r3_ax        <= n_ax;

            r4_side      <= r3_side;
            r4_prod      <= r3_seed * n_twom;

            r5_side      <= r4_side;
            r5_x1        <= n_x1;

            if (r5_side.zero) begin
                r6_recip <= MAX_Q16;
                r6_dbz   <= 1'b1;
                r6_sat   <= 1'b1;
            end else begin
                r6_recip <= n_sat ? MAX_Q16 : n_res[15:0];
                r6_dbz   <= 1'b0;
                r6_sat   <= n_sat;
            end
        end
    end

    assign o_recip     = r6_recip;
    assign o_div_zero  = r6_dbz;
    assign o_saturated = r6_sat;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_dbz_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_div_zero) |-> (o_saturated && o_recip == MAX_Q16))
        else $error("divide by zero item without saturated all-ones result");

    a_sat_ones: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_saturated) |-> (o_recip == MAX_Q16))
        else $error("saturated item with result other than all ones");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> r_vld[1])
        else $error("accepted item did not enter the first stage");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(r_vld)))
        else $error("pipeline moved while the output stalled");

endmodule

`default_nettype wire

[tb/reciprocal_u16_to_q16_core_tb.sv]
// Self-checking testbench for the Q0.16 reciprocal core: directed and random items.
`timescale 1ns / 1ps

module reciprocal_u16_to_q16_core_tb;

    import recip_pkg::*;

    localparam int unsigned CLK_PERIOD   = 8;
    localparam int unsigned RESET_CYCLES = 7;
    localparam int unsigned RANDOM_ITEMS = 850;
    // Quiet stretch: neither side idles for these random items.
    localparam int unsigned QUIET_FIRST  = 350;
    localparam int unsigned QUIET_LAST   = 549;
    // Six-stage pipe; keep the clock running after the last result to catch stray items.
    localparam int unsigned DRAIN_CYCLES = 24;
    // Far above the length of the slowest legal run.
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned IDLE_PERCENT = 8;

    // One expected result, tagged with the item value that caused it.
    typedef struct {
        logic [VALUE_W-1:0] value;
        logic [VALUE_W-1:0] recip;
        logic               div_zero;
        logic               saturated;
    } t_recip_result;

    // Scoreboard: predicts the reciprocal of each accepted item and
    // checks results in order against the oldest prediction.
    class recip_scoreboard;
        t_recip_result pending_recips[$];
        int unsigned   mismatches;

        function new();
            mismatches = 0;
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            mismatches++;
        endtask

        // Normalize, seed lookup, one Newton step, rounded denormalize.
        function t_recip_result predict_recip(logic [VALUE_W-1:0] value);
            t_recip_result      r;
            int unsigned        pos;
            int unsigned        divisor;
            logic [15:0]        mant;
            logic [7:0]         seed_idx;
            logic [16:0]        seed;
            logic [31:0]        ax;
            logic [16:0]        two_minus_ax;
            logic [33:0]        prod;
            logic [18:0]        x1;
            logic [18:0]        res;
            r.value     = value;
            r.div_zero  = 1'b0;
            r.saturated = 1'b0;
            if (value == '0) begin
                r.recip     = MAX_Q16;
                r.div_zero  = 1'b1;
                r.saturated = 1'b1;
                return r;
            end
            pos = 0;
            for (int i = 0; i < VALUE_W; i++)
                if (value[i])
                    pos = i;
            mant     = value << (15 - pos);
            seed_idx = mant[14:7];
            divisor  = SEED_BASE + 2 * seed_idx;
            seed     = 17'((SEED_NUM + divisor) / (2 * divisor));
            ax       = (32'(mant) * 32'(seed)) >> 16;
            if (ax > 32'(FULL_Q16))
                ax = 32'(FULL_Q16);
            two_minus_ax = FULL_Q16 - 17'(ax);
            prod = 34'(seed) * 34'(two_minus_ax) + NR_ROUND;
            x1   = 19'(prod >> 15);
            // Newton clamp: does not count as saturation
            if (x1 > 19'(MAX_Q16))
                x1 = 19'(MAX_Q16);
            if (pos == 0)
                res = x1;
            else
                res = (x1 + (19'd1 << (pos - 1))) >> pos;
            if (res > 19'(MAX_Q16)) begin
                res         = 19'(MAX_Q16);
                r.saturated = 1'b1;
            end
            r.recip = res[15:0];
            return r;
        endfunction

        function void note_input(logic [VALUE_W-1:0] value);
            pending_recips.push_back(predict_recip(value));
        endfunction

        task check_result(logic [VALUE_W-1:0] recip, logic dbz, logic sat);
            t_recip_result exp_r;
            if (pending_recips.size() == 0) begin
                report_mismatch($sformatf("result recip=%h with no item pending", recip));
                return;
            end
            exp_r = pending_recips.pop_front();
            if (recip !== exp_r.recip)
                report_mismatch($sformatf("value=%h recip got %h want %h",
                                          exp_r.value, recip, exp_r.recip));
            if (dbz !== exp_r.div_zero)
                report_mismatch($sformatf("value=%h div_zero got %b want %b",
                                          exp_r.value, dbz, exp_r.div_zero));
            if (sat !== exp_r.saturated)
                report_mismatch($sformatf("value=%h saturated got %b want %b",
                                          exp_r.value, sat, exp_r.saturated));
        endtask

        function int unsigned pending();
            return pending_recips.size();
        endfunction
    endclass

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic [VALUE_W-1:0] i_value = '0;
    logic               i_ready = 1'b0;
    logic               o_ready;
    logic               o_valid;
    logic [VALUE_W-1:0] o_recip;
    logic               o_div_zero;
    logic               o_saturated;

    logic               quiet = 1'b0;
    int unsigned        cycle_count = 0;
    recip_scoreboard    sb = new();

    reciprocal_u16_to_q16_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_recip     (o_recip),
        .o_div_zero  (o_div_zero),
        .o_saturated (o_saturated)
    );

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Watchdog: a hung pipe or a lost item ends the run here.
    initial begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge i_clk);
        $display("FAIL reciprocal_u16_to_q16_core");
        $finish;
    end

    // Result side: values read right after the edge are the pre-edge ones,
    // so the handshake seen here is the one the block saw.
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready)
                sb.check_result(o_recip, o_div_zero, o_saturated);
            if (quiet)
                i_ready <= 1'b1;
            else
                i_ready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    // Offer one item; valid stays up between back-to-back items.
    // Outside the quiet stretch, each idle cycle is drawn on its own, with an IDLE_PERCENT chance.
    task send_item(logic [VALUE_W-1:0] value);
        while (!quiet && $urandom_range(0, 99) < IDLE_PERCENT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_value <= value;
        do
            @(posedge i_clk);
        while (!o_ready);
        sb.note_input(value);
    endtask

    // Spread items over all magnitudes, not just the top octave.
    function automatic logic [VALUE_W-1:0] pick_value();
        int unsigned sel;
        int unsigned pos;
        logic [VALUE_W-1:0] one_hot;
        sel     = $urandom_range(0, 99);
        pos     = $urandom_range(0, VALUE_W - 1);
        one_hot = 16'd1 << pos;
        if (sel < 40)
            return 16'($urandom());
        else if (sel < 70)
            return one_hot | (16'($urandom()) & (one_hot - 16'd1));
        else if (sel < 82)
            return 16'($urandom_range(0, 15));
        else if (sel < 95)
            return one_hot + 16'($urandom_range(0, 2)) - 16'd1;
        else
            return '0;
    endfunction

    logic [VALUE_W-1:0] directed_values[$] = '{
        16'h0000, 16'h0001, 16'h0002, 16'h0003, 16'hFFFF,
        16'h8000, 16'h7FFF, 16'h8001, 16'h00FF, 16'h0100,
        16'h0101, 16'h5555, 16'hAAAA, 16'h0080, 16'h0081,
        16'h007F, 16'h0180, 16'hC000, 16'hFF80, 16'hFF7F,
        16'h0000, 16'h0005, 16'h4000, 16'h00C3
    };

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: zero, one, octave edges, seed index edges
        foreach (directed_values[i])
            send_item(directed_values[i]);

        for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == QUIET_FIRST)
                quiet <= 1'b1;
            else if (n == QUIET_LAST + 1)
                quiet <= 1'b0;
            send_item(pick_value());
        end
        i_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.mismatches == 0)
            $display("PASS reciprocal_u16_to_q16_core");
        else
            $display("FAIL reciprocal_u16_to_q16_core");
        $finish;
    end

endmodule
